[src/histogram_2d_bin_fill_top_defines.svh]
// ----------------------------------------------------------------------------
// histogram_2d_bin_fill_top_defines.svh
// Assertion macros used by the histogram fill engine controller.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_2D_BIN_FILL_TOP_DEFINES_SVH
`define HISTOGRAM_2D_BIN_FILL_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define H2D_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define H2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/hist2d_pkg.sv]
// ----------------------------------------------------------------------------
// hist2d_pkg
// Shared types and constants of the histogram fill engine.
// ----------------------------------------------------------------------------
package hist2d_pkg;

	localparam int DEF_MAX_I_BINS = 64;
	localparam int DEF_MAX_J_BINS = 64;

	localparam int VAL_W     = 32;
	localparam int BINS_W    = 7;
	localparam int IDX_W     = 6;
	localparam int KIND_W    = 2;
	localparam int REG_IDX_W = 3;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_FILL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_I_BINS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_J_BINS  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_I_MIN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_I_MAX   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_I_SCALE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_J_MIN   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_J_MAX   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_J_SCALE = 3'd7;

	// register reset values
	localparam logic [BINS_W-1:0] RST_I_BINS = 7'd64;
	localparam logic [BINS_W-1:0] RST_J_BINS = 7'd0;
	localparam logic [VAL_W-1:0]  RST_MIN    = 32'h0000_0000;
	localparam logic [VAL_W-1:0]  RST_MAX    = 32'h0040_0000; // 64.0
	localparam logic [VAL_W-1:0]  RST_SCALE  = 32'h0001_0000; // 1.0

	localparam logic [VAL_W-1:0] COUNT_SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [BINS_W-1:0] i_bins;
		logic [BINS_W-1:0] j_bins;
		logic [VAL_W-1:0]  i_min;
		logic [VAL_W-1:0]  i_max;
		logic [VAL_W-1:0]  i_scale;
		logic [VAL_W-1:0]  j_min;
		logic [VAL_W-1:0]  j_max;
		logic [VAL_W-1:0]  j_scale;
	} cfg_t;

	// controller -> datapath step enables
	typedef struct packed {
		logic capture;
		logic diff;
		logic mul;
		logic addr;
		logic rd;
		logic wr;
		logic clr;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage

[src/hist2d_cfg.sv]
// ----------------------------------------------------------------------------
// hist2d_cfg
// Configuration register file of the histogram fill engine.
// ----------------------------------------------------------------------------
module hist2d_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [hist2d_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [hist2d_pkg::VAL_W-1:0]         wr_data,
	output hist2d_pkg::cfg_t                     cfg
);

	localparam int BW = hist2d_pkg::BINS_W;

	hist2d_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.i_bins  <= hist2d_pkg::RST_I_BINS;
			cfg_q.j_bins  <= hist2d_pkg::RST_J_BINS;
			cfg_q.i_min   <= hist2d_pkg::RST_MIN;
			cfg_q.i_max   <= hist2d_pkg::RST_MAX;
			cfg_q.i_scale <= hist2d_pkg::RST_SCALE;
			cfg_q.j_min   <= hist2d_pkg::RST_MIN;
			cfg_q.j_max   <= hist2d_pkg::RST_MAX;
			cfg_q.j_scale <= hist2d_pkg::RST_SCALE;
		end else if (wr_en) begin
			unique case (wr_index)
				hist2d_pkg::REG_I_BINS:  cfg_q.i_bins  <= wr_data[BW-1:0];
				hist2d_pkg::REG_J_BINS:  cfg_q.j_bins  <= wr_data[BW-1:0];
				hist2d_pkg::REG_I_MIN:   cfg_q.i_min   <= wr_data;
				hist2d_pkg::REG_I_MAX:   cfg_q.i_max   <= wr_data;
				hist2d_pkg::REG_I_SCALE: cfg_q.i_scale <= wr_data;
				hist2d_pkg::REG_J_MIN:   cfg_q.j_min   <= wr_data;
				hist2d_pkg::REG_J_MAX:   cfg_q.j_max   <= wr_data;
				hist2d_pkg::REG_J_SCALE: cfg_q.j_scale <= wr_data;
				default:                 cfg_q.i_bins  <= cfg_q.i_bins;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/hist2d_dp.sv]
// ----------------------------------------------------------------------------
// hist2d_dp
// Datapath: range check, bin multiply, flat address, count store.
// ----------------------------------------------------------------------------
module hist2d_dp #(
	parameter int MAX_I_BINS = hist2d_pkg::DEF_MAX_I_BINS,
	parameter int MAX_J_BINS = hist2d_pkg::DEF_MAX_J_BINS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hist2d_pkg::cmd_t                  cmd,
	output hist2d_pkg::sts_t                  sts,
	input  hist2d_pkg::cfg_t                  cfg,
	input  logic [hist2d_pkg::KIND_W-1:0]     kind,
	input  logic [hist2d_pkg::VAL_W-1:0]      i_value,
	input  logic [hist2d_pkg::VAL_W-1:0]      j_value,
	input  logic [hist2d_pkg::IDX_W-1:0]      i_index,
	input  logic [hist2d_pkg::IDX_W-1:0]      j_index,
	output logic                              in_range,
	output logic                              counted,
	output logic [hist2d_pkg::VAL_W-1:0]      bin_count,
	output logic                              done
);

	localparam int VW    = hist2d_pkg::VAL_W;
	localparam int BW    = hist2d_pkg::BINS_W;
	localparam int DEPTH = MAX_I_BINS * MAX_J_BINS;
	localparam int IW    = (MAX_I_BINS > 1) ? $clog2(MAX_I_BINS) : 1;
	localparam int JW    = (MAX_J_BINS > 1) ? $clog2(MAX_J_BINS) : 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// captured item
	logic [hist2d_pkg::KIND_W-1:0] kind_q;
	logic [VW-1:0]                 i_value_q, j_value_q;
	logic [hist2d_pkg::IDX_W-1:0]  i_index_q, j_index_q;

	// pipeline registers
	logic          rng_s1;
	logic [VW-1:0] diff_i_s1, diff_j_s1;
	logic [VW-1:0] ib_s2, jb_s2;
	logic [AW-1:0] addr_s3;
	logic          hit_s3;
	logic [VW-1:0] rd_data_q;

	// control
	logic [AW-1:0] clr_idx_q;
	logic          done_q;

	// result
	logic          in_range_q, counted_q;
	logic [VW-1:0] bin_count_q;

	logic [VW-1:0] mem [DEPTH];

	// effective bin counts
	logic [BW-1:0] ni, nj;
	logic          one_d;

	always_comb begin
		if (cfg.i_bins == '0)
			ni = BW'(1);
		else if (32'(cfg.i_bins) > MAX_I_BINS)
			ni = BW'(MAX_I_BINS);
		else
			ni = cfg.i_bins;
		if (32'(cfg.j_bins) > MAX_J_BINS)
			nj = BW'(MAX_J_BINS);
		else
			nj = cfg.j_bins;
	end

	assign one_d = (cfg.j_bins == '0);

	logic is_fill, is_acc, is_clear;
	assign is_fill  = (kind_q == hist2d_pkg::KIND_FILL);
	assign is_clear = (kind_q == hist2d_pkg::KIND_CLEAR);
	assign is_acc   = (kind_q == hist2d_pkg::KIND_READ) || is_clear;

	// range check and offset from lower edge; in range the offset is
	// non-negative and below 2^32, so the low 32 bits hold it exactly
	logic          i_ok, j_ok;
	logic [VW-1:0] di_w, dj_w;

	assign i_ok = ($signed(i_value_q) >= $signed(cfg.i_min)) &&
		($signed(i_value_q) <= $signed(cfg.i_max));
	assign j_ok = ($signed(j_value_q) >= $signed(cfg.j_min)) &&
		($signed(j_value_q) <= $signed(cfg.j_max));
	assign di_w = i_value_q - cfg.i_min;
	assign dj_w = j_value_q - cfg.j_min;

	// Q32.32 products, keep integer part
	logic [2*VW-1:0] prod_i, prod_j;
	assign prod_i = (2*VW)'(diff_i_s1) * (2*VW)'(cfg.i_scale);
	assign prod_j = (2*VW)'(diff_j_s1) * (2*VW)'(cfg.j_scale);

	// bin select, bound check, flat address
	logic [VW-1:0] a_i, a_j;
	logic [JW-1:0] j_idx;
	logic          sel_ok, hit_w;
	logic [AW-1:0] flat_w;

	always_comb begin
		a_i    = is_fill ? ib_s2 : VW'(i_index_q);
		a_j    = is_fill ? jb_s2 : VW'(j_index_q);
		sel_ok = (a_i < VW'(ni)) && (one_d || (a_j < VW'(nj)));
		hit_w  = sel_ok && (is_fill ? rng_s1 : is_acc);
		j_idx  = one_d ? '0 : a_j[JW-1:0];
		flat_w = AW'(a_i[IW-1:0]) + AW'(AW'(j_idx) * AW'(ni));
	end

	// write-back data: saturating increment or zero
	logic [VW-1:0] wdata;
	logic          mem_we;
	assign wdata  = is_fill ? ((rd_data_q == hist2d_pkg::COUNT_SAT) ? rd_data_q
		: rd_data_q + VW'(1)) : '0;
	assign mem_we = cmd.wr && hit_s3 && (is_fill || is_clear);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= kind;
			i_value_q <= i_value;
			j_value_q <= j_value;
			i_index_q <= i_index;
			j_index_q <= j_index;
		end
		if (cmd.diff) begin
			rng_s1    <= i_ok && (one_d || j_ok);
			diff_i_s1 <= di_w;
			diff_j_s1 <= dj_w;
		end
		if (cmd.mul) begin
			ib_s2 <= prod_i[2*VW-1:VW];
			jb_s2 <= one_d ? '0 : prod_j[2*VW-1:VW];
		end
		if (cmd.addr) begin
			addr_s3 <= flat_w;
			hit_s3  <= hit_w;
		end
		if (cmd.wr) begin
			in_range_q  <= is_fill && rng_s1;
			counted_q   <= is_fill && hit_s3;
			bin_count_q <= (is_acc && hit_s3) ? rd_data_q : '0;
		end
	end

	// count store
	always_ff @(posedge clk) begin
		if (cmd.clr)
			mem[clr_idx_q] <= '0;
		else if (mem_we)
			mem[addr_s3] <= wdata;
		if (cmd.rd)
			rd_data_q <= mem[addr_s3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.clr)
				clr_idx_q <= clr_idx_q + AW'(1);
			done_q <= cmd.wr;
		end
	end

	assign sts.clr_last = (clr_idx_q == AW'(DEPTH - 1));

	assign in_range  = in_range_q;
	assign counted   = counted_q;
	assign bin_count = bin_count_q;
	assign done      = done_q;

endmodule

[src/hist2d_ctrl.sv]
// ----------------------------------------------------------------------------
// hist2d_ctrl
// Controller: clear sweep after reset, then one item through the steps.
// ----------------------------------------------------------------------------
`include "histogram_2d_bin_fill_top_defines.svh"

module hist2d_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output hist2d_pkg::cmd_t cmd,
	input  hist2d_pkg::sts_t sts
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIFF  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_ADDR  = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

	// at most one step active per cycle
	`H2D_ASSERT_SAME(a_one_step, 1'b1, $onehot0(cmd), "more than one step enable active")
	// accepted item moves straight into the pipeline
	`H2D_ASSERT_NEXT(a_accept, start && !busy, state_q == ST_DIFF, "accepted item not started")
	// write-back always follows a store read
	`H2D_ASSERT_SAME(a_rd_wr, cmd.wr, $past(cmd.rd), "write-back without read")
	// end of clear sweep opens the block
	`H2D_ASSERT_NEXT(a_clr_end, cmd.clr && sts.clr_last, !busy, "clear sweep did not end")

endmodule

[src/histogram_2d_bin_fill_top.sv]
// ----------------------------------------------------------------------------
// histogram_2d_bin_fill_top
// 1-D / 2-D histogram fill engine with a saturating 32-bit count store.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// --------  ---------  -----------------  ----------------------------------
// item      in         start & !busy      kind, i_value, j_value, i_index,
//                                         j_index
// result    out        done (one cycle)   in_range, counted, bin_count
// config    in         wr_en              wr_index, wr_data
//
// - Each item steps through capture, range check, multiply, address, read
//   and write-back before the next accept; done is registered at write-back.
// - The item time is set by the read-modify-write of the single-port count
//   store behind a registered range check and a registered bin multiply.
// - After reset the store is zeroed one entry per cycle
//   (MAX_I_BINS * MAX_J_BINS entries, 4096 at default); busy stays high.
// - The receiver cannot stall: done is high for one cycle only; the payload holds until the next result.
// - The user writes config only while idle; the block does not enforce it.
//
module histogram_2d_bin_fill_top #(
	parameter int MAX_I_BINS = hist2d_pkg::DEF_MAX_I_BINS,
	parameter int MAX_J_BINS = hist2d_pkg::DEF_MAX_J_BINS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item
	input  logic                                start,
	output logic                                busy,
	input  logic [hist2d_pkg::KIND_W-1:0]       kind,
	input  logic [hist2d_pkg::VAL_W-1:0]        i_value,
	input  logic [hist2d_pkg::VAL_W-1:0]        j_value,
	input  logic [hist2d_pkg::IDX_W-1:0]        i_index,
	input  logic [hist2d_pkg::IDX_W-1:0]        j_index,
	// result
	output logic                                done,
	output logic                                in_range,
	output logic                                counted,
	output logic [hist2d_pkg::VAL_W-1:0]        bin_count,
	// config
	input  logic                                wr_en,
	input  logic [hist2d_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [hist2d_pkg::VAL_W-1:0]        wr_data
);

	hist2d_pkg::cfg_t cfg;
	hist2d_pkg::cmd_t cmd;
	hist2d_pkg::sts_t sts;

	// register file
	hist2d_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// sequencing: clear sweep, then capture/diff/mul/addr/read/write
	hist2d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// range check, bin multiply, address and count store
	hist2d_dp #(
		.MAX_I_BINS (MAX_I_BINS),
		.MAX_J_BINS (MAX_J_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg),
		.kind      (kind),
		.i_value   (i_value),
		.j_value   (j_value),
		.i_index   (i_index),
		.j_index   (j_index),
		.in_range  (in_range),
		.counted   (counted),
		.bin_count (bin_count),
		.done      (done)
	);

endmodule
